>>> hw/rtl/tesf_pkg.sv
// ----------------------------------------------------------------------------
// tesf_pkg: shared types and constants
// Transaction types, sequencer states, divider selection and saturation
// helpers for the triple exponential smoothing forecaster.
// ----------------------------------------------------------------------------
package tesf_pkg;

    localparam int SMP_W    = 32;
    localparam int LVL_FRAC = 16;
    localparam int LVL_W    = SMP_W + LVL_FRAC;
    localparam int SUM_W    = SMP_W + 2;
    localparam int COEF_W   = 8;
    localparam int PROD_W   = LVL_W + COEF_W + 1;
    localparam int DIV_W    = 64;
    localparam int DIG_W    = 8;
    localparam int DIGITS   = DIV_W / DIG_W;
    localparam int DCNT_W   = $clog2(DIGITS);
    localparam int REM_W    = 4;
    localparam int V_W      = REM_W + DIG_W;
    localparam int RECIP_W  = 15;
    localparam int RECIP_SH = 16;
    localparam int FC_SHIFT = LVL_FRAC;

    // 9 * 2^16 rounding: bias by half the divisor, drop 16 bits, divide by 9
    localparam logic [DIV_W-1:0] FC_BIAS = DIV_W'(9) << (FC_SHIFT - 1);

    // forecast step m: 9*(3s1-3s2+s3) + m*(22s1-38s2+16s3); middle term subtracted
    localparam logic [COEF_W-1:0] FC_COEF [0:2][0:2] = '{
        '{8'd49, 8'd65,  8'd25},
        '{8'd71, 8'd103, 8'd41},
        '{8'd93, 8'd141, 8'd57}
    };

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    last;
    } t_in;

    typedef struct packed {
        logic signed [SMP_W-1:0] forecast_one;
        logic signed [SMP_W-1:0] forecast_two;
        logic signed [SMP_W-1:0] forecast_three;
        logic                    too_few;
    } t_out;

    typedef enum logic [1:0] {
        DIV_SEED,
        DIV_STEP,
        DIV_FCAST
    } t_div_sel;

    typedef struct packed {
        logic     start;
        t_div_sel sel;
    } t_div_req;

    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic signed [DIV_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_DIGIT,
        DV_SIGN
    } t_div_state;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_SEED_W,
        ST_SM_START,
        ST_SM_W,
        ST_FC_MUL,
        ST_FC_ACC,
        ST_FC_DIV,
        ST_FC_W,
        ST_EMIT
    } t_state;

    function automatic logic signed [LVL_W-1:0] sat_lvl(input logic signed [DIV_W-1:0] v);
        logic fits;
        fits = (&v[DIV_W-1:LVL_W-1]) | ~(|v[DIV_W-1:LVL_W-1]);
        if (fits) begin
            return v[LVL_W-1:0];
        end else if (v[DIV_W-1]) begin
            return {1'b1, {(LVL_W-1){1'b0}}};
        end else begin
            return {1'b0, {(LVL_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [DIV_W-1:0] v);
        logic fits;
        fits = (&v[DIV_W-1:SMP_W-1]) | ~(|v[DIV_W-1:SMP_W-1]);
        if (fits) begin
            return v[SMP_W-1:0];
        end else if (v[DIV_W-1]) begin
            return {1'b1, {(SMP_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SMP_W-1){1'b1}}};
        end
    endfunction

endpackage

>>> hw/rtl/tesf_div.sv
// ----------------------------------------------------------------------------
// tesf_div: rounding divider by a small constant
// Signed numerator, divisor 3, 5 or 9 (after a 16-bit drop), rounded to
// nearest with ties away from zero. One 8-bit quotient digit per cycle.
// ----------------------------------------------------------------------------
module tesf_div
    import tesf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_div_req                i_req,
    input  logic signed [DIV_W-1:0] i_num,
    output t_div_rsp                o_rsp
);

    t_div_state             r_state, n_state;
    t_div_sel               r_sel, n_sel;
    logic [DIV_W-1:0]       r_m, n_m;
    logic [REM_W-1:0]       r_rem, n_rem;
    logic [DCNT_W-1:0]      r_cnt, n_cnt;
    logic                   r_neg, n_neg;
    logic                   r_done, n_done;
    logic signed [DIV_W-1:0] r_quot, n_quot;

    logic                   neg;
    logic [DIV_W-1:0]       base, addend, bsum, load_m;
    logic [REM_W-1:0]       dvsr;
    logic [RECIP_W-1:0]     recip;
    logic [V_W-1:0]         v, back, rem_full;
    logic [V_W+RECIP_W-1:0] prod;
    logic [DIG_W-1:0]       qd;

    always_comb begin
        neg  = i_num[DIV_W-1];
        base = neg ? ~i_num : i_num;
        case (i_req.sel)
            DIV_SEED:  addend = DIV_W'(1);
            DIV_STEP:  addend = DIV_W'(2);
            DIV_FCAST: addend = FC_BIAS;
            default:   addend = '0;
        endcase
        addend = addend + DIV_W'(neg);
        bsum   = base + addend;
        load_m = (i_req.sel == DIV_FCAST) ? (bsum >> FC_SHIFT) : bsum;
    end

    always_comb begin
        case (r_sel)
            DIV_SEED: begin
                dvsr  = REM_W'(3);
                recip = RECIP_W'(21846);
            end
            DIV_STEP: begin
                dvsr  = REM_W'(5);
                recip = RECIP_W'(13108);
            end
            DIV_FCAST: begin
                dvsr  = REM_W'(9);
                recip = RECIP_W'(7282);
            end
            default: begin
                dvsr  = REM_W'(5);
                recip = RECIP_W'(13108);
            end
        endcase
        v        = {r_rem, r_m[DIV_W-1 -: DIG_W]};
        prod     = {{RECIP_W{1'b0}}, v} * {{V_W{1'b0}}, recip};
        qd       = prod[RECIP_SH +: DIG_W];
        back     = {{REM_W{1'b0}}, qd} * {{DIG_W{1'b0}}, dvsr};
        rem_full = v - back;
    end

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_m     = r_m;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_done  = 1'b0;
        n_quot  = r_quot;
        case (r_state)
            DV_IDLE: begin
                if (i_req.start) begin
                    n_sel   = i_req.sel;
                    n_m     = load_m;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_neg   = neg;
                    n_state = DV_DIGIT;
                end
            end
            DV_DIGIT: begin
                n_m   = {r_m[DIV_W-DIG_W-1:0], qd};
                n_rem = rem_full[REM_W-1:0];
                n_cnt = r_cnt + DCNT_W'(1);
                if (r_cnt == DCNT_W'(DIGITS - 1)) begin
                    n_state = DV_SIGN;
                end
            end
            DV_SIGN: begin
                n_quot  = r_neg ? -$signed(r_m) : $signed(r_m);
                n_done  = 1'b1;
                n_state = DV_IDLE;
            end
            default: begin
                n_state = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel  <= n_sel;
        r_m    <= n_m;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_quot <= n_quot;
    end

    assign o_rsp.busy = (r_state != DV_IDLE);
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_state == DV_IDLE))
        else $error("divider started while busy");

    a_done_after_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DV_SIGN) |=> (r_done && r_state == DV_IDLE))
        else $error("divider result not flagged after sign stage");

endmodule

>>> hw/rtl/triple_exponential_smoothing_forecast.sv
// ----------------------------------------------------------------------------
// triple_exponential_smoothing_forecast: Brown triple smoothing forecaster
// Seeds three levels with the mean of the first three samples, smooths with
// factor 0.4; emits 1-, 2- and 3-step forecasts on the last sample, or too_few.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_stall    t_in  (sample, last)
//  out      output     o_out_valid / i_out_stall  t_out (three forecasts, too_few)
//
//  An ordinary sample runs three level updates, each through the shared
//  digit-serial divider (8 digit steps plus load, sign, ack). The third sample
//  also runs the seed division and replays all three held samples; the last
//  sample adds the forecast plus the emit state. Synchronous active-low reset
//  clears count, levels and handshake state. A waiting result does not stall
//  input; only a new result waits for it.
// ----------------------------------------------------------------------------
module triple_exponential_smoothing_forecast
    import tesf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_state                   r_state, n_state;
    logic [1:0]               r_count, n_count;
    logic signed [LVL_W-1:0]  r_l1, n_l1, r_l2, n_l2, r_l3, n_l3;
    logic signed [SMP_W-1:0]  r_first [0:2];
    logic signed [SMP_W-1:0]  n_first [0:2];
    logic signed [SMP_W-1:0]  r_x, n_x;
    logic [1:0]               r_k, n_k;
    logic [1:0]               r_fidx, n_fidx;
    logic                     r_replay, n_replay;
    logic                     r_last, n_last;
    logic                     r_short, n_short;
    logic [1:0]               r_m, n_m;
    logic [1:0]               r_t, n_t;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [DIV_W-1:0]  r_acc, n_acc;
    logic signed [SMP_W-1:0]  r_fc1, n_fc1, r_fc2, n_fc2, r_fc3, n_fc3;
    logic                     r_out_valid, n_out_valid;
    t_out                     r_out, n_out;

    t_div_req                 div_req;
    t_div_rsp                 div_rsp;
    logic signed [DIV_W-1:0]  div_num;

    logic                     accept, out_free;
    logic signed [SUM_W-1:0]  sum3;
    logic signed [LVL_W-1:0]  tgt, lvl, lvl_t;
    logic signed [LVL_W:0]    diff;
    logic signed [DIV_W-1:0]  upd;
    logic signed [LVL_W-1:0]  new_lvl;
    logic signed [SMP_W-1:0]  fc_val;

    tesf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .o_rsp   (div_rsp)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        sum3 = {{2{r_first[0][SMP_W-1]}}, r_first[0]}
             + {{2{r_first[1][SMP_W-1]}}, r_first[1]}
             + {{2{r_first[2][SMP_W-1]}}, r_first[2]};
        case (r_k)
            2'd0: begin
                tgt = {r_x, {LVL_FRAC{1'b0}}};
                lvl = r_l1;
            end
            2'd1: begin
                tgt = r_l1;
                lvl = r_l2;
            end
            default: begin
                tgt = r_l2;
                lvl = r_l3;
            end
        endcase
        diff    = {tgt[LVL_W-1], tgt} - {lvl[LVL_W-1], lvl};
        upd     = {{(DIV_W-LVL_W){lvl[LVL_W-1]}}, lvl} + div_rsp.quot;
        new_lvl = sat_lvl(upd);
        fc_val  = sat_smp(div_rsp.quot);
        case (r_t)
            2'd0:    lvl_t = r_l1;
            2'd1:    lvl_t = r_l2;
            default: lvl_t = r_l3;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_l1        = r_l1;
        n_l2        = r_l2;
        n_l3        = r_l3;
        n_first     = r_first;
        n_x         = r_x;
        n_k         = r_k;
        n_fidx      = r_fidx;
        n_replay    = r_replay;
        n_last      = r_last;
        n_short     = r_short;
        n_m         = r_m;
        n_t         = r_t;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_fc1       = r_fc1;
        n_fc2       = r_fc2;
        n_fc3       = r_fc3;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        div_req     = '{start: 1'b0, sel: DIV_STEP};
        div_num     = {{(DIV_W-LVL_W-2){diff[LVL_W]}}, diff, 1'b0};

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_last  = i_in_data.last;
                    n_short = 1'b0;
                    if (r_count != 2'd3) begin
                        n_first[r_count] = i_in_data.sample;
                        n_count          = r_count + 2'd1;
                        if (r_count == 2'd2) begin
                            n_state = ST_SEED;
                        end else if (i_in_data.last) begin
                            n_short = 1'b1;
                            n_state = ST_EMIT;
                        end
                    end else begin
                        n_x      = i_in_data.sample;
                        n_k      = 2'd0;
                        n_replay = 1'b0;
                        n_state  = ST_SM_START;
                    end
                end
            end
            ST_SEED: begin
                div_req = '{start: 1'b1, sel: DIV_SEED};
                div_num = {{(DIV_W-SUM_W-LVL_FRAC){sum3[SUM_W-1]}}, sum3, {LVL_FRAC{1'b0}}};
                n_state = ST_SEED_W;
            end
            ST_SEED_W: begin
                if (div_rsp.done) begin
                    n_l1     = sat_lvl(div_rsp.quot);
                    n_l2     = sat_lvl(div_rsp.quot);
                    n_l3     = sat_lvl(div_rsp.quot);
                    n_replay = 1'b1;
                    n_fidx   = 2'd0;
                    n_x      = r_first[0];
                    n_k      = 2'd0;
                    n_state  = ST_SM_START;
                end
            end
            ST_SM_START: begin
                div_req = '{start: 1'b1, sel: DIV_STEP};
                n_state = ST_SM_W;
            end
            ST_SM_W: begin
                if (div_rsp.done) begin
                    case (r_k)
                        2'd0:    n_l1 = new_lvl;
                        2'd1:    n_l2 = new_lvl;
                        default: n_l3 = new_lvl;
                    endcase
                    if (r_k != 2'd2) begin
                        n_k     = r_k + 2'd1;
                        n_state = ST_SM_START;
                    end else if (r_replay && r_fidx != 2'd2) begin
                        n_fidx  = r_fidx + 2'd1;
                        n_x     = r_first[r_fidx + 2'd1];
                        n_k     = 2'd0;
                        n_state = ST_SM_START;
                    end else begin
                        n_replay = 1'b0;
                        if (r_last) begin
                            n_m     = 2'd0;
                            n_t     = 2'd0;
                            n_acc   = '0;
                            n_state = ST_FC_MUL;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_FC_MUL: begin
                n_prod  = PROD_W'(lvl_t) * PROD_W'($signed({1'b0, FC_COEF[r_m][r_t]}));
                n_state = ST_FC_ACC;
            end
            ST_FC_ACC: begin
                if (r_t == 2'd1) begin
                    n_acc = r_acc - {{(DIV_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
                end else begin
                    n_acc = r_acc + {{(DIV_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
                end
                if (r_t == 2'd2) begin
                    n_state = ST_FC_DIV;
                end else begin
                    n_t     = r_t + 2'd1;
                    n_state = ST_FC_MUL;
                end
            end
            ST_FC_DIV: begin
                div_req = '{start: 1'b1, sel: DIV_FCAST};
                div_num = r_acc;
                n_state = ST_FC_W;
            end
            ST_FC_W: begin
                if (div_rsp.done) begin
                    case (r_m)
                        2'd0:    n_fc1 = fc_val;
                        2'd1:    n_fc2 = fc_val;
                        default: n_fc3 = fc_val;
                    endcase
                    if (r_m == 2'd2) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_m     = r_m + 2'd1;
                        n_t     = 2'd0;
                        n_acc   = '0;
                        n_state = ST_FC_MUL;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out.forecast_one   = r_short ? '0 : r_fc1;
                    n_out.forecast_two   = r_short ? '0 : r_fc2;
                    n_out.forecast_three = r_short ? '0 : r_fc3;
                    n_out.too_few        = r_short;
                    n_out_valid          = 1'b1;
                    n_count              = 2'd0;
                    n_l1                 = '0;
                    n_l2                 = '0;
                    n_l3                 = '0;
                    n_state              = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= 2'd0;
            r_l1        <= '0;
            r_l2        <= '0;
            r_l3        <= '0;
            r_replay    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_l1        <= n_l1;
            r_l2        <= n_l2;
            r_l3        <= n_l3;
            r_replay    <= n_replay;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_x     <= n_x;
        r_k     <= n_k;
        r_fidx  <= n_fidx;
        r_last  <= n_last;
        r_short <= n_short;
        r_m     <= n_m;
        r_t     <= n_t;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_fc1   <= n_fc1;
        r_fc2   <= n_fc2;
        r_fc3   <= n_fc3;
        r_out   <= n_out;
    end

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_SEED_W || r_state == ST_SM_W || r_state == ST_FC_W))
        else $error("divider result arrived outside a wait state");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider request while divider busy");

    a_fc_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FC_MUL || r_state == ST_FC_ACC) |-> (r_t != 2'd3 && r_m != 2'd3))
        else $error("forecast term index out of range");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && out_free) |=> (r_count == 2'd0 && o_out_valid))
        else $error("series state not cleared on result transaction");

    a_replay_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SM_START) |-> (r_count == 2'd3))
        else $error("smoothing before three samples held");

endmodule

>>> bench/triple_exponential_smoothing_forecast_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triple_exponential_smoothing_forecast_tb: forecaster testbench
// Sends series of Q16.16 samples in random bursts while the result side stalls
// on its own pattern. A bit-exact model of the Brown smoothing predicts the
// forecasts of every marked sample; each result is checked field by field.
// ----------------------------------------------------------------------------
module triple_exponential_smoothing_forecast_tb;
    import tesf_pkg::*;

    localparam int     ITEM_TARGET = 1250;
    localparam int     CYCLE_LIMIT = 1_500_000;
    localparam int     TAIL_CYCLES = 400;
    localparam longint SAT_BIG     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic [SMP_W-1:0] MAX_SMP = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic [SMP_W-1:0] MIN_SMP = {1'b1, {(SMP_W-1){1'b0}}};
    localparam logic [SMP_W-1:0] ONE_Q16 = 32'h0001_0000;

    typedef enum int {
        SER_NOISE,
        SER_RAMP,
        SER_EXTREME,
        SER_JITTER
    } t_series_style;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;

    t_out forecast_q[$];
    int   mismatch_count = 0;
    int   samples_sent   = 0;
    int   burst_left     = 0;
    int   cycle_count    = 0;
    int   stall_mode     = 0;
    int   stall_left     = 0;

    longint held_smp[3];
    int     held_cnt;
    longint lvl_s1, lvl_s2, lvl_s3;

    triple_exponential_smoothing_forecast DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---- saturating 64-bit arithmetic ----
    function automatic longint clamp_neg(input longint v);
        return (v < -SAT_BIG) ? -SAT_BIG : v;
    endfunction

    function automatic longint add_sat(input longint x, input longint y);
        if (y > 0 && x > SAT_BIG - y) return SAT_BIG;
        if (y < 0 && x < -SAT_BIG - y) return -SAT_BIG;
        return x + y;
    endfunction

    function automatic longint mul_sat(input longint v, input longint c);
        if (c == 0) return 0;
        if (v > SAT_BIG / c) return SAT_BIG;
        if (v < -(SAT_BIG / c)) return -SAT_BIG;
        return v * c;
    endfunction

    function automatic longint round_div(input longint n, input longint unsigned d);
        logic                neg;
        longint unsigned     mag;
        longint unsigned     q;
        neg = (n < 0);
        mag = neg ? longint'(-clamp_neg(n)) : n;
        q   = (mag + d / 2) / d;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clip_width(input longint v, input int w);
        longint lim;
        lim = (longint'(1) <<< (w - 1)) - 1;
        if (v > lim) return lim;
        if (v < -lim - 1) return -lim - 1;
        return v;
    endfunction

    // ---- smoothing levels ----
    function automatic longint smooth_level(input longint lvl, input longint target);
        longint diff;
        longint step;
        diff = add_sat(target, -clamp_neg(lvl));
        step = round_div(mul_sat(diff, 2), 5);
        return clip_width(add_sat(lvl, step), LVL_W);
    endfunction

    task automatic smooth_all(input longint x);
        longint xl;
        xl     = mul_sat(x, longint'(1) <<< LVL_FRAC);
        lvl_s1 = smooth_level(lvl_s1, xl);
        lvl_s2 = smooth_level(lvl_s2, lvl_s1);
        lvl_s3 = smooth_level(lvl_s3, lvl_s2);
    endtask

    function automatic logic [SMP_W-1:0] brown_forecast(input longint m);
        longint n;
        n = 0;
        n = add_sat(n, mul_sat(lvl_s1, 27 + 22 * m));
        n = add_sat(n, -mul_sat(lvl_s2, 27 + 38 * m));
        n = add_sat(n, mul_sat(lvl_s3, 9 + 16 * m));
        n = round_div(n, longint'(9) <<< LVL_FRAC);
        n = clip_width(n, SMP_W);
        return n[SMP_W-1:0];
    endfunction

    task automatic clear_series();
        held_cnt = 0;
        lvl_s1   = 0;
        lvl_s2   = 0;
        lvl_s3   = 0;
    endtask

    task automatic predict_sample(input t_in item);
        longint x;
        longint seed;
        t_out   res;
        x = longint'($signed(item.sample));
        if (held_cnt < 3) begin
            held_smp[held_cnt] = x;
            held_cnt++;
            if (held_cnt == 3) begin
                seed = round_div(mul_sat(held_smp[0] + held_smp[1] + held_smp[2],
                                         longint'(1) <<< LVL_FRAC), 3);
                seed   = clip_width(seed, LVL_W);
                lvl_s1 = seed;
                lvl_s2 = seed;
                lvl_s3 = seed;
                smooth_all(held_smp[0]);
                smooth_all(held_smp[1]);
                smooth_all(held_smp[2]);
            end
        end else begin
            smooth_all(x);
        end
        if (item.last) begin
            if (held_cnt < 3) begin
                res = '0;
                res.too_few = 1'b1;
            end else begin
                res.forecast_one   = brown_forecast(1);
                res.forecast_two   = brown_forecast(2);
                res.forecast_three = brown_forecast(3);
                res.too_few        = 1'b0;
            end
            forecast_q.push_back(res);
            clear_series();
        end
    endtask

    // ---- input side: bursts with random gaps ----
    task automatic send_sample(input logic [SMP_W-1:0] value, input logic is_last);
        t_in item;
        int  gap;
        item.sample = value;
        item.last   = is_last;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_sample(item);
        samples_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            in_valid       <= 1'b0;
            in_data.sample <= $urandom;
            in_data.last   <= 1'($urandom_range(0, 1));
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // ---- output side: stall pattern ----
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: begin
                out_stall <= 1'b0;
            end
            1: begin
                out_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                out_stall <= 1'($urandom_range(0, 1));
            end
            default: begin
                out_stall <= ($urandom_range(0, 15) != 0);
            end
        endcase
    end

    // ---- result checking ----
    task automatic compare_field(input string field, input logic [SMP_W-1:0] want,
                                 input logic [SMP_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (forecast_q.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, got %h",
                         $time, out_data);
                mismatch_count++;
            end else begin
                want = forecast_q.pop_front();
                compare_field("forecast_one", want.forecast_one, out_data.forecast_one);
                compare_field("forecast_two", want.forecast_two, out_data.forecast_two);
                compare_field("forecast_three", want.forecast_three,
                              out_data.forecast_three);
                compare_field("too_few", SMP_W'(want.too_few), SMP_W'(out_data.too_few));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d transactions outstanding", $time, forecast_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---- tests ----
    task automatic test_short_series();
        send_sample(ONE_Q16, 1'b1);
        send_sample(MIN_SMP, 1'b0);
        send_sample(MAX_SMP, 1'b1);
    endtask

    task automatic test_extreme_series();
        repeat (2) send_sample(MAX_SMP, 1'b0);
        send_sample(MAX_SMP, 1'b1);
        repeat (2) send_sample(MIN_SMP, 1'b0);
        send_sample(MIN_SMP, 1'b1);
        send_sample(MAX_SMP, 1'b0);
        send_sample(MIN_SMP, 1'b0);
        send_sample(MAX_SMP, 1'b0);
        send_sample(MIN_SMP, 1'b1);
    endtask

    task automatic test_ramp_series();
        repeat (3) send_sample('0, 1'b0);
        send_sample('1, 1'b1);
        for (int k = 1; k <= 5; k++) begin
            send_sample(ONE_Q16 * k, k == 5);
        end
    endtask

    function automatic logic [SMP_W-1:0] series_value(input t_series_style style,
                                                      input int idx,
                                                      input logic [SMP_W-1:0] base,
                                                      input logic [SMP_W-1:0] slope);
        case (style)
            SER_NOISE: begin
                return $urandom;
            end
            SER_RAMP: begin
                return base + slope * idx;
            end
            SER_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return MAX_SMP;
                    1: return MIN_SMP;
                    2: return '0;
                    3: return '1;
                    default: return base;
                endcase
            end
            default: begin
                return base + $urandom_range(0, 2047) - 1024;
            end
        endcase
    endfunction

    task automatic test_random_series();
        int               len;
        int               pick;
        t_series_style    style;
        logic [SMP_W-1:0] base;
        logic [SMP_W-1:0] slope;
        while (samples_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                len = $urandom_range(1, 2);
            end else if (pick == 1) begin
                len = $urandom_range(13, 50);
            end else begin
                len = $urandom_range(3, 10);
            end
            style = t_series_style'($urandom_range(0, 3));
            base  = $signed($urandom) >>> $urandom_range(0, 12);
            slope = $signed($urandom) >>> $urandom_range(4, 24);
            for (int k = 0; k < len; k++) begin
                send_sample(series_value(style, k, base, slope), k == len - 1);
            end
        end
    endtask

    initial begin
        clear_series();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_short_series();
        test_extreme_series();
        test_ramp_series();
        test_random_series();

        @(negedge clk);
        in_valid <= 1'b0;
        while (forecast_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (forecast_q.size() != 0) begin
            $display("%0t: %0d transactions never arrived", $time, forecast_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
